@@ sv/i2c_register_master_defines.svh @@
// assertion macros shared by the i2c register master checker
// no dependencies; included by files that hold concurrent assertions
`ifndef I2C_REGISTER_MASTER_DEFINES_SVH
`define I2C_REGISTER_MASTER_DEFINES_SVH

// same-cycle implication, disabled while reset is applied
`define I2CRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("i2crm assertion failed");

// next-cycle implication, disabled while reset is applied
`define I2CRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("i2crm assertion failed");

`endif

@@ sv/i2crm_pkg.sv @@
// types and constants for the i2c register master
// no dependencies; imported by i2c_register_master
`timescale 1ns / 1ps

package i2crm_pkg;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned BitCntWidth = 4;
  localparam logic [BitCntWidth-1:0] BitsPerByte = 4'd8;
  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_WBIT_LOW  = 4'd3,
    PH_WBIT_HIGH = 4'd4,
    PH_ACK_HOLD  = 4'd5,
    PH_ACK_LOW   = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_RBIT_LOW  = 4'd8,
    PH_RBIT_HIGH = 4'd9,
    PH_MACK_LOW  = 4'd10,
    PH_MACK_HIGH = 4'd11,
    PH_STOP_LOW  = 4'd12,
    PH_STOP_HIGH = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DEV   = 2'd0,
    KIND_REG   = 2'd1,
    KIND_DEVRD = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

endpackage

@@ sv/i2c_register_master.sv @@
// i2c register master: bus sequencer advanced by one tick per input transaction
// depends on i2crm_pkg
`timescale 1ns / 1ps

// Each input transaction is one bus timing tick and yields exactly one result
// transaction in the next cycle; a tick can be accepted in any unstalled cycle.
// The sequencer state sits in registers and one pass of short next-state logic
// advances it; the result sits in a single output register that is refilled
// in the same cycle it is taken. Input is stalled only while that register
// holds an untaken result. delay_ticks sets the number of ticks per half-bit
// segment (0 behaves as 1); write it only while the bus is idle.
module i2c_register_master (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2crm_pkg::DelayWidth-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [7:0]                     dev_addr_i,
  input  logic [7:0]                     reg_addr_i,
  input  logic [7:0]                     length_i,
  input  logic [7:0]                     tx_byte_i,
  input  logic                           sda_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_level_o,
  output logic                           sda_level_o,
  output logic                           busy_res_o,
  output logic                           tx_taken_o,
  output logic                           rx_valid_o,
  output logic [7:0]                     rx_byte_o,
  output logic                           rx_last_o,
  output logic                           ack_valid_o,
  output logic                           ack_seen_o
);
  import i2crm_pkg::*;

  logic [DelayWidth-1:0]  delay_ticks_q;
  phase_e                 phase_q, phase_d;
  kind_e                  kind_q, kind_d;
  logic [BitCntWidth-1:0] bit_count_q, bit_count_d;
  logic [7:0]             byte_count_q, byte_count_d;
  logic [7:0]             shift_q, shift_d;
  logic [7:0]             saved_device_q, saved_device_d;
  logic [7:0]             saved_register_q, saved_register_d;
  logic                   read_mode_q, read_mode_d;
  logic [DelayWidth-1:0]  delay_count_q, delay_count_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;

  logic                   out_valid_q;
  logic                   tx_taken_q, rx_valid_q, rx_last_q, ack_valid_q, ack_seen_q;
  logic [7:0]             rx_byte_q;
  logic                   tx_taken_d, rx_valid_d, rx_last_d, ack_valid_d, ack_seen_d;
  logic [7:0]             rx_byte_d;

  logic                   in_acc;
  logic [DelayWidth:0]    cnt_next;
  logic                   seg_end;
  logic                   active;
  logic [BitCntWidth-1:0] bit_next;
  logic [7:0]             shift_rx;
  logic [7:0]             byte_dec;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign cnt_next = {1'b0, delay_count_q} + {{DelayWidth{1'b0}}, 1'b1};
  assign seg_end  = cnt_next >= {1'b0, delay_ticks_q};
  assign active   = in_acc && (phase_q != PH_IDLE) && seg_end;
  assign bit_next = bit_count_q + {{(BitCntWidth-1){1'b0}}, 1'b1};
  assign shift_rx = {shift_q[6:0], sda_in_i};
  assign byte_dec = byte_count_q - 8'd1;

  // next state of the sequencer
  always_comb begin
    phase_d          = phase_q;
    kind_d           = kind_q;
    bit_count_d      = bit_count_q;
    byte_count_d     = byte_count_q;
    shift_d          = shift_q;
    saved_device_d   = saved_device_q;
    saved_register_d = saved_register_q;
    read_mode_d      = read_mode_q;
    delay_count_d    = delay_count_q;
    scl_d            = scl_q;
    sda_d            = sda_q;
    if (in_acc) begin
      if (phase_q == PH_IDLE) begin
        if (command_i == CMD_WRITE || command_i == CMD_READ) begin
          saved_device_d   = dev_addr_i;
          saved_register_d = reg_addr_i;
          byte_count_d     = length_i;
          read_mode_d      = (command_i == CMD_READ);
          kind_d           = KIND_DEV;
          phase_d          = PH_START_A;
          scl_d            = 1'b1;
          sda_d            = 1'b1;
          delay_count_d    = '0;
        end
      end else if (!seg_end) begin
        delay_count_d = cnt_next[DelayWidth-1:0];
      end else begin
        delay_count_d = '0;
        unique case (phase_q)
          PH_START_A: begin
            phase_d = PH_START_B;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_START_B: begin
            // repeated start sends the device address with the read bit set
            shift_d     = (kind_q == KIND_DEVRD) ? (saved_device_q | ReadBit)
                                                 : saved_device_q;
            kind_d      = (kind_q == KIND_DEVRD) ? KIND_DEVRD : KIND_DEV;
            bit_count_d = '0;
            phase_d     = PH_WBIT_LOW;
            scl_d       = 1'b0;
            sda_d       = (kind_q == KIND_DEVRD) ? (saved_device_q[7] | ReadBit[7])
                                                 : saved_device_q[7];
          end
          PH_WBIT_LOW: begin
            phase_d = PH_WBIT_HIGH;
            scl_d   = 1'b1;
          end
          PH_WBIT_HIGH: begin
            shift_d     = {shift_q[6:0], 1'b0};
            bit_count_d = bit_next;
            scl_d       = 1'b0;
            if (bit_next < BitsPerByte) begin
              phase_d = PH_WBIT_LOW;
              sda_d   = shift_q[6];
            end else begin
              phase_d = PH_ACK_HOLD;
            end
          end
          PH_ACK_HOLD: begin
            phase_d = PH_ACK_LOW;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end
          PH_ACK_LOW: begin
            phase_d = PH_ACK_HIGH;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_ACK_HIGH: begin
            scl_d = 1'b0;
            if (kind_q == KIND_DEV) begin
              kind_d      = KIND_REG;
              shift_d     = saved_register_q;
              bit_count_d = '0;
              phase_d     = PH_WBIT_LOW;
              sda_d       = saved_register_q[7];
            end else if (kind_q == KIND_REG && read_mode_q) begin
              kind_d  = KIND_DEVRD;
              phase_d = PH_START_A;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
            end else if (kind_q == KIND_DEVRD) begin
              if (byte_count_q != 8'd0) begin
                bit_count_d = '0;
                shift_d     = '0;
                phase_d     = PH_RBIT_LOW;
                sda_d       = 1'b1;
              end else begin
                phase_d = PH_STOP_LOW;
                sda_d   = 1'b0;
              end
            end else if (byte_count_q != 8'd0) begin
              byte_count_d = byte_dec;
              kind_d       = KIND_DATA;
              shift_d      = tx_byte_i;
              bit_count_d  = '0;
              phase_d      = PH_WBIT_LOW;
              sda_d        = tx_byte_i[7];
            end else begin
              phase_d = PH_STOP_LOW;
              sda_d   = 1'b0;
            end
          end
          PH_RBIT_LOW: begin
            phase_d = PH_RBIT_HIGH;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_RBIT_HIGH: begin
            shift_d     = shift_rx;
            bit_count_d = bit_next;
            scl_d       = 1'b0;
            if (bit_next < BitsPerByte) begin
              phase_d = PH_RBIT_LOW;
              sda_d   = 1'b1;
            end else begin
              // ack every byte but the last, which gets a nack
              byte_count_d = byte_dec;
              phase_d      = PH_MACK_LOW;
              sda_d        = (byte_dec == 8'd0);
            end
          end
          PH_MACK_LOW: begin
            phase_d = PH_MACK_HIGH;
            scl_d   = 1'b1;
          end
          PH_MACK_HIGH: begin
            scl_d = 1'b0;
            if (byte_count_q != 8'd0) begin
              bit_count_d = '0;
              shift_d     = '0;
              phase_d     = PH_RBIT_LOW;
              sda_d       = 1'b1;
            end else begin
              phase_d = PH_STOP_LOW;
              sda_d   = 1'b0;
            end
          end
          PH_STOP_LOW: begin
            phase_d = PH_STOP_HIGH;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          default: begin
            phase_d = PH_IDLE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
        endcase
      end
    end
  end

  // per-tick result flags
  always_comb begin
    tx_taken_d  = 1'b0;
    rx_valid_d  = 1'b0;
    rx_byte_d   = '0;
    rx_last_d   = 1'b0;
    ack_valid_d = 1'b0;
    ack_seen_d  = 1'b0;
    if (active) begin
      unique case (phase_q)
        PH_ACK_HIGH: begin
          ack_valid_d = 1'b1;
          ack_seen_d  = ~sda_in_i;
          tx_taken_d  = (kind_q == KIND_DATA || (kind_q == KIND_REG && !read_mode_q))
                        && byte_count_q != 8'd0;
        end
        PH_RBIT_HIGH: begin
          if (!(bit_next < BitsPerByte)) begin
            rx_valid_d = 1'b1;
            rx_byte_d  = shift_rx;
            rx_last_d  = (byte_dec == 8'd0);
          end
        end
        default: begin
          tx_taken_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q    <= {{(DelayWidth-1){1'b0}}, 1'b1};
      phase_q          <= PH_IDLE;
      kind_q           <= KIND_DEV;
      bit_count_q      <= '0;
      byte_count_q     <= '0;
      shift_q          <= '0;
      saved_device_q   <= '0;
      saved_register_q <= '0;
      read_mode_q      <= 1'b0;
      delay_count_q    <= '0;
      scl_q            <= 1'b1;
      sda_q            <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_ticks_q <= cfg_wdata_i;
      end
      phase_q          <= phase_d;
      kind_q           <= kind_d;
      bit_count_q      <= bit_count_d;
      byte_count_q     <= byte_count_d;
      shift_q          <= shift_d;
      saved_device_q   <= saved_device_d;
      saved_register_q <= saved_register_d;
      read_mode_q      <= read_mode_d;
      delay_count_q    <= delay_count_d;
      scl_q            <= scl_d;
      sda_q            <= sda_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_taken_q  <= tx_taken_d;
      rx_valid_q  <= rx_valid_d;
      rx_byte_q   <= rx_byte_d;
      rx_last_q   <= rx_last_d;
      ack_valid_q <= ack_valid_d;
      ack_seen_q  <= ack_seen_d;
    end
  end

  // drive levels and busy are the state after the tick, so they come from the
  // sequencer registers, which only move on an accepted tick
  assign out_valid_o = out_valid_q;
  assign scl_level_o = scl_q;
  assign sda_level_o = sda_q;
  assign busy_res_o  = (phase_q != PH_IDLE);
  assign tx_taken_o  = tx_taken_q;
  assign rx_valid_o  = rx_valid_q;
  assign rx_byte_o   = rx_byte_q;
  assign rx_last_o   = rx_last_q;
  assign ack_valid_o = ack_valid_q;
  assign ack_seen_o  = ack_seen_q;

endmodule

@@ sv/i2crm_checker.sv @@
// port-level checks for the i2c register master, bound to the top level
// depends on i2c_register_master_defines.svh and i2c_register_master
`timescale 1ns / 1ps
`include "i2c_register_master_defines.svh"

module i2crm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_level_o,
  input logic       sda_level_o,
  input logic       busy_res_o,
  input logic       tx_taken_o,
  input logic       rx_valid_o,
  input logic [7:0] rx_byte_o,
  input logic       rx_last_o,
  input logic       ack_valid_o,
  input logic       ack_seen_o
);

  // a stalled result transaction holds
  `I2CRM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(rx_byte_o) && $stable(tx_taken_o) && $stable(ack_valid_o))

  // input is only held off by a waiting result
  `I2CRM_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a data byte is fetched only at the end of an acknowledge slot
  `I2CRM_ASSERT_IMPLY(a_tx_on_ack, clk_i, rst_ni, out_valid_o && tx_taken_o, ack_valid_o && busy_res_o && !scl_level_o)

  // a read byte completes with scl low, never in an ack slot
  `I2CRM_ASSERT_IMPLY(a_rx_slot, clk_i, rst_ni, out_valid_o && rx_valid_o, busy_res_o && !scl_level_o && !ack_valid_o && sda_level_o == rx_last_o)

  // report fields stay clear without their strobes
  `I2CRM_ASSERT_IMPLY(a_quiet_fields, clk_i, rst_ni, out_valid_o && !rx_valid_o && !ack_valid_o, rx_byte_o == 8'd0 && !rx_last_o && !ack_seen_o)

endmodule

bind i2c_register_master i2crm_checker u_i2crm_checker (.*);

@@ sim/i2crm_tick_scoreboard.sv @@
// scoreboard for the i2c register master: predicts the bus drive of every tick
// and checks each result transaction against it; depends on i2crm_pkg
`timescale 1ns / 1ps

package i2crm_tick_scoreboard_pkg;
  import i2crm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       ack_valid;
    logic       ack_seen;
  } tick_result_t;

  class i2c_tick_scoreboard;
    // bus sequencer state
    phase_e                     bus_phase;
    kind_e                      byte_kind;
    logic [BitCntWidth-1:0]     bits_done;
    logic [7:0]                 bytes_left;
    logic [7:0]                 shifter;
    logic [7:0]                 dev_byte;
    logic [7:0]                 reg_byte;
    logic [7:0]                 len_byte;
    logic                       rd_txn;
    logic [DelayWidth-1:0]      seg_count;
    logic                       scl_q;
    logic                       sda_q;
    logic [DelayWidth-1:0]      half_bit;

    tick_result_t expected_drive_q[$];

    int unsigned ticks;
    int unsigned writes_begun;
    int unsigned reads_begun;
    int unsigned bytes_read;
    int unsigned bytes_fed;
    int unsigned ack_slots;
    int unsigned nacks;
    int unsigned mismatches;

    function new();
      bus_phase = PH_IDLE;
      byte_kind = KIND_DEV;
      bits_done = '0;
      bytes_left = '0;
      shifter = '0;
      dev_byte = '0;
      reg_byte = '0;
      len_byte = '0;
      rd_txn = 1'b0;
      seg_count = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      half_bit = 16'd1;
    endfunction

    function void set_half_bit(logic [DelayWidth-1:0] value);
      half_bit = value;
    endfunction

    function bit bus_idle();
      return bus_phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction

    function void enter(phase_e p, logic scl, logic sda);
      bus_phase = p;
      scl_q = scl;
      sda_q = sda;
      seg_count = '0;
    endfunction

    function void send_byte(logic [7:0] value, kind_e k);
      byte_kind = k;
      shifter = value;
      bits_done = '0;
      enter(PH_WBIT_LOW, 1'b0, value[7]);
    endfunction

    function void read_next();
      if (bytes_left != 0) begin
        bits_done = '0;
        shifter = '0;
        enter(PH_RBIT_LOW, 1'b0, 1'b1);
      end else begin
        enter(PH_STOP_LOW, 1'b0, 1'b0);
      end
    endfunction

    // advance the sequencer by one accepted tick and queue the drive it yields
    function void note_tick(logic [1:0] cmd, logic [7:0] dev, logic [7:0] reg_addr,
                            logic [7:0] len, logic [7:0] txb, logic sda_i);
      tick_result_t r;
      int unsigned cnt;
      r = '0;
      ticks++;
      if (bus_phase == PH_IDLE) begin
        if (cmd == CMD_WRITE || cmd == CMD_READ) begin
          dev_byte = dev;
          reg_byte = reg_addr;
          len_byte = len;
          bytes_left = len;
          rd_txn = (cmd == CMD_READ);
          byte_kind = KIND_DEV;
          if (rd_txn) reads_begun++;
          else writes_begun++;
          enter(PH_START_A, 1'b1, 1'b1);
        end
      end else begin
        cnt = int'(seg_count) + 1;
        if (cnt < int'(half_bit)) begin
          seg_count = cnt[DelayWidth-1:0];
        end else begin
          case (bus_phase)
            PH_START_A: enter(PH_START_B, 1'b1, 1'b0);
            PH_START_B: begin
              if (byte_kind == KIND_DEVRD) send_byte(dev_byte | ReadBit, KIND_DEVRD);
              else send_byte(dev_byte, KIND_DEV);
            end
            PH_WBIT_LOW: enter(PH_WBIT_HIGH, 1'b1, sda_q);
            PH_WBIT_HIGH: begin
              shifter = shifter << 1;
              bits_done = bits_done + 1'b1;
              if (bits_done < BitsPerByte) enter(PH_WBIT_LOW, 1'b0, shifter[7]);
              else enter(PH_ACK_HOLD, 1'b0, sda_q);
            end
            PH_ACK_HOLD: enter(PH_ACK_LOW, 1'b0, 1'b1);
            PH_ACK_LOW: enter(PH_ACK_HIGH, 1'b1, 1'b1);
            PH_ACK_HIGH: begin
              r.ack_valid = 1'b1;
              r.ack_seen = ~sda_i;
              if (byte_kind == KIND_DEV) begin
                send_byte(reg_byte, KIND_REG);
              end else if (byte_kind == KIND_REG && rd_txn) begin
                byte_kind = KIND_DEVRD;
                enter(PH_START_A, 1'b1, 1'b1);
              end else if (byte_kind == KIND_DEVRD) begin
                read_next();
              end else if (bytes_left != 0) begin
                // next write byte is fetched on the ack tick
                bytes_left = bytes_left - 1'b1;
                send_byte(txb, KIND_DATA);
                r.tx_taken = 1'b1;
              end else begin
                enter(PH_STOP_LOW, 1'b0, 1'b0);
              end
            end
            PH_RBIT_LOW: enter(PH_RBIT_HIGH, 1'b1, 1'b1);
            PH_RBIT_HIGH: begin
              shifter = {shifter[6:0], sda_i};
              bits_done = bits_done + 1'b1;
              if (bits_done < BitsPerByte) begin
                enter(PH_RBIT_LOW, 1'b0, 1'b1);
              end else begin
                bytes_left = bytes_left - 1'b1;
                r.rx_valid = 1'b1;
                r.rx_byte = shifter;
                r.rx_last = (bytes_left == 0);
                // nack the final byte by releasing sda
                enter(PH_MACK_LOW, 1'b0, r.rx_last);
              end
            end
            PH_MACK_LOW: enter(PH_MACK_HIGH, 1'b1, sda_q);
            PH_MACK_HIGH: read_next();
            PH_STOP_LOW: enter(PH_STOP_HIGH, 1'b1, 1'b0);
            default: enter(PH_IDLE, 1'b1, 1'b1);
          endcase
        end
      end
      r.scl = scl_q;
      r.sda = sda_q;
      r.busy = (bus_phase != PH_IDLE);
      expected_drive_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report(what, got, want);
    endtask

    task check_drive(tick_result_t got);
      tick_result_t want;
      if (expected_drive_q.size() == 0) begin
        report("result with no tick pending", int'(got), 0);
        return;
      end
      want = expected_drive_q.pop_front();
      if (want.rx_valid) bytes_read++;
      if (want.tx_taken) bytes_fed++;
      if (want.ack_valid) ack_slots++;
      if (want.ack_valid && !want.ack_seen) nacks++;
      compare_field("scl_level", got.scl, want.scl);
      compare_field("sda_level", got.sda, want.sda);
      compare_field("busy_res", got.busy, want.busy);
      compare_field("tx_taken", got.tx_taken, want.tx_taken);
      compare_field("rx_valid", got.rx_valid, want.rx_valid);
      compare_field("rx_byte", got.rx_byte, want.rx_byte);
      compare_field("rx_last", got.rx_last, want.rx_last);
      compare_field("ack_valid", got.ack_valid, want.ack_valid);
      compare_field("ack_seen", got.ack_seen, want.ack_seen);
    endtask
  endclass

endpackage

@@ sim/i2c_register_master_tb.sv @@
// testbench top for i2c_register_master: directed and random tick streams with
// bursty input and stalling output; depends on i2crm_pkg and i2crm_tick_scoreboard_pkg
`timescale 1ns / 1ps

module i2c_register_master_tb;
  import i2crm_pkg::*;
  import i2crm_tick_scoreboard_pkg::*;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int HoldCycles = 400;
  localparam int StallLimit = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [7:0]  dev_addr;
  logic [7:0]  reg_addr;
  logic [7:0]  length;
  logic [7:0]  tx_byte;
  logic        sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        tx_taken;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        rx_last;
  logic        ack_valid;
  logic        ack_seen;

  i2c_tick_scoreboard sb;

  int  stall_mode;
  int  sda_pick;
  int  tx_pick;
  int  burst_left;
  int  idle_cycles;
  int  pat_cnt;
  bit  gaps_on;
  bit  hold_req;
  int  ph;

  i2c_register_master u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .dev_addr_i  (dev_addr),
    .reg_addr_i  (reg_addr),
    .length_i    (length),
    .tx_byte_i   (tx_byte),
    .sda_in_i    (sda_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .scl_level_o (scl_level),
    .sda_level_o (sda_level),
    .busy_res_o  (busy_res),
    .tx_taken_o  (tx_taken),
    .rx_valid_o  (rx_valid),
    .rx_byte_o   (rx_byte),
    .rx_last_o   (rx_last),
    .ack_valid_o (ack_valid),
    .ack_seen_o  (ack_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // both channels are observed here, inputs noted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_tick(command, dev_addr, reg_addr, length, tx_byte, sda_in);
      end
      if (out_valid && !out_stall) begin
        sb.check_drive('{scl: scl_level, sda: sda_level, busy: busy_res,
                         tx_taken: tx_taken, rx_valid: rx_valid, rx_byte: rx_byte,
                         rx_last: rx_last, ack_valid: ack_valid, ack_seen: ack_seen});
      end
    end
  end

  // receiver side: own stall pattern plus one long hold-off on request
  initial begin
    pat_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 2) == 0);
        default: begin
          out_stall = ((pat_cnt % 5) < 2);
          pat_cnt++;
        end
      endcase
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", StallLimit);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] pick_tx();
    case (tx_pick)
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic pick_sda();
    case (sda_pick)
      0: return 1'b0;
      1: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // offer one tick at a falling edge and hold it until accepted;
  // returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] c, logic [7:0] d, logic [7:0] r, logic [7:0] l);
    bit acc;
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1'b1;
    command = c;
    dev_addr = d;
    reg_addr = r;
    length = l;
    tx_byte = pick_tx();
    sda_in = pick_sda();
    acc = 1'b0;
    while (!acc) begin
      @(posedge clk);
      acc = in_valid && !in_stall;
      @(negedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // with hammer set every tick carries a write, read or unknown command, which a busy block ignores
  task automatic tick_until_idle(bit hammer);
    while (!sb.bus_idle()) begin
      if (hammer) begin
        send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic run_txn(logic [1:0] c, logic [7:0] d, logic [7:0] r, logic [7:0] l,
                         bit hammer);
    send_item(c, d, r, l);
    tick_until_idle(hammer);
  endtask

  // the register is written only once every result has drained
  task automatic set_delay(logic [15:0] value);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_half_bit(value);
  endtask

  task automatic random_ticks(int n);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 19);
      if (sb.bus_idle()) begin
        if (k < 16) begin
          send_item(2'($urandom_range(1, 2)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)),
                    (k < 3) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(0, 4)));
        end else if (k < 18) begin
          send_tick();
        end else begin
          send_item(CmdUnknown, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        end
      end else if (k == 0) begin
        send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_TICK;
    dev_addr = '0;
    reg_addr = '0;
    length = '0;
    tx_byte = '0;
    sda_in = 1'b1;
    out_stall = 1'b0;
    stall_mode = 0;
    sda_pick = 2;
    tx_pick = 2;
    burst_left = 0;
    gaps_on = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset delay of one tick per half bit
    sda_pick = 0;
    tx_pick = 0;
    run_txn(CMD_WRITE, 8'h00, 8'h00, 8'd0, 1'b0);
    sda_pick = 1;
    tx_pick = 1;
    run_txn(CMD_WRITE, 8'hFF, 8'hFF, 8'd2, 1'b0);
    sda_pick = 2;
    tx_pick = 2;
    run_txn(CMD_READ, 8'hA0, 8'h10, 8'd0, 1'b0);
    sda_pick = 0;
    run_txn(CMD_READ, 8'hFE, 8'h01, 8'd3, 1'b0);
    sda_pick = 1;
    stall_mode = 2;
    run_txn(CMD_READ, 8'h55, 8'hAA, 8'd2, 1'b1);
    sda_pick = 2;
    send_item(CmdUnknown, 8'hFF, 8'hFF, 8'hFF);
    send_tick();
    gaps_on = 1'b1;
    stall_mode = 1;
    run_txn(CMD_WRITE, 8'h3C, 8'hC3, 8'd1, 1'b1);

    // zero delay behaves as one
    set_delay(16'd0);
    run_txn(CMD_WRITE, 8'h6A, 8'h95, 8'd1, 1'b0);
    run_txn(CMD_READ, 8'h95, 8'h6A, 8'd1, 1'b0);

    // longest delay, then shortened while a segment is already past the new count
    set_delay(16'hFFFF);
    send_item(CMD_WRITE, 8'h42, 8'h24, 8'd1);
    repeat (6) send_tick();
    set_delay(16'd2);
    tick_until_idle(1'b0);

    // random traffic over several delay settings; the third phase holds the
    // output off for a long stretch while ticks keep coming
    for (ph = 0; ph < 4; ph++) begin
      set_delay((ph == 3) ? 16'd0 : 16'($urandom_range(1, 3)));
      stall_mode = ph % 3;
      gaps_on = (ph == 1 || ph == 3);
      if (ph == 2) hold_req = 1'b1;
      random_ticks(40);
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d ticks: %0d writes and %0d reads begun, %0d bytes sent, %0d bytes read",
             sb.ticks, sb.writes_begun, sb.reads_begun, sb.bytes_fed, sb.bytes_read);
    $display("%0d acknowledge slots sampled, %0d of them not acknowledged",
             sb.ack_slots, sb.nacks);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ i2c_register_master.f @@
+incdir+sv
sv/i2crm_pkg.sv
sv/i2c_register_master.sv
sv/i2crm_checker.sv
sim/i2crm_tick_scoreboard.sv
sim/i2c_register_master_tb.sv
